// ----- sv/lnc_pkg.sv -----
// Shared types, constants and saturating fixed-point helpers for the lattice node collision block.
package lnc_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 28;
    localparam int QUO_BITS    = WORD_BITS + FRAC_BITS;
    localparam int DIV_LAT     = QUO_BITS + 2;
    localparam int LANE_LAT    = 7;
    localparam int NUM_DIRS    = 9;
    localparam int RELAX_BITS  = WORD_BITS - 2;
    localparam int SOURCE_BITS = WORD_BITS - 3;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam word_t ONE_Q       = word_t'(64'd1 << FRAC_BITS);
    localparam word_t WEIGHT_REST = word_t'(((64'd4 << FRAC_BITS) + 64'd4) / 64'd9);
    localparam word_t WEIGHT_AXIS = word_t'(((64'd1 << FRAC_BITS) + 64'd4) / 64'd9);
    localparam word_t WEIGHT_DIAG = word_t'(((64'd1 << FRAC_BITS) + 64'd18) / 64'd36);

    localparam logic [RELAX_BITS-1:0]  RELAX_RESET  = RELAX_BITS'(64'd1 << FRAC_BITS);
    localparam logic [SOURCE_BITS-1:0] SOURCE_RESET = SOURCE_BITS'(64'd1 << (FRAC_BITS - 1));

    localparam int DIR_X [NUM_DIRS] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [NUM_DIRS] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

    typedef enum logic [1:0] {
        CFG_FORCE_X,
        CFG_FORCE_Y,
        CFG_RELAX_RATE,
        CFG_SOURCE_FACTOR
    } cfg_reg_t;

    typedef struct packed {
        word_t pop_rest;
        word_t pop_east;
        word_t pop_north;
        word_t pop_west;
        word_t pop_south;
        word_t pop_northeast;
        word_t pop_northwest;
        word_t pop_southwest;
        word_t pop_southeast;
        logic  force_row;
    } in_item_t;

    typedef struct packed {
        word_t out_rest;
        word_t out_east;
        word_t out_north;
        word_t out_west;
        word_t out_south;
        word_t out_northeast;
        word_t out_northwest;
        word_t out_southwest;
        word_t out_southeast;
        word_t velocity_x;
        word_t velocity_y;
        logic  bad_density;
    } out_item_t;

    typedef struct packed {
        word_t [NUM_DIRS-1:0] pop;
        word_t                rho;
        word_t                force_x;
        word_t                force_y;
        logic                 bad;
    } node_side_t;

    typedef struct packed {
        word_t vel_x;
        word_t vel_y;
        word_t force_x;
        word_t force_y;
        word_t rho;
        word_t usq_scaled;
        word_t uf_scaled;
    } lane_ctx_t;

    typedef struct packed {
        word_t vel_x;
        word_t vel_y;
        logic  bad;
    } vel_info_t;

    function automatic word_t sat_add(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t pick(int e, word_t v);
        if (e > 0)
            return v;
        if (e < 0)
            return sat_sub('0, v);
        return '0;
    endfunction

    // halve, truncating toward zero
    function automatic word_t half_tz(word_t a);
        logic [WORD_BITS:0] t;
        t = {a[WORD_BITS-1], a} + {{WORD_BITS{1'b0}}, a[WORD_BITS-1]};
        return t[WORD_BITS:1];
    endfunction

    function automatic word_t clamp_wide(logic [WORD_BITS+3:0] x);
        if ((&x[WORD_BITS+3:WORD_BITS-1]) || !(|x[WORD_BITS+3:WORD_BITS-1]))
            return x[WORD_BITS-1:0];
        return x[WORD_BITS+3] ? WORD_MIN : WORD_MAX;
    endfunction

    function automatic word_t times3(word_t a);
        logic [WORD_BITS+3:0] e;
        e = {{4{a[WORD_BITS-1]}}, a};
        return clamp_wide(e + (e << 1));
    endfunction

    function automatic word_t times4(word_t a);
        logic [WORD_BITS+3:0] e;
        e = {{4{a[WORD_BITS-1]}}, a};
        return clamp_wide(e << 2);
    endfunction

    function automatic word_t times9(word_t a);
        logic [WORD_BITS+3:0] e;
        e = {{4{a[WORD_BITS-1]}}, a};
        return clamp_wide((e << 3) + e);
    endfunction

    function automatic word_t apply_sign(logic neg, logic [WORD_BITS-1:0] m);
        return neg ? word_t'(~m + 1'b1) : word_t'(m);
    endfunction

    // product shifted down by the fraction bits, truncated toward zero, saturated
    function automatic word_t sat_mul(word_t a, word_t b);
        logic [WORD_BITS-1:0]   ma;
        logic [WORD_BITS-1:0]   mb;
        logic [2*WORD_BITS-1:0] p;
        logic [2*WORD_BITS-1:0] s;
        logic                   neg;
        ma  = a[WORD_BITS-1] ? (~a + 1'b1) : a;
        mb  = b[WORD_BITS-1] ? (~b + 1'b1) : b;
        p   = {{WORD_BITS{1'b0}}, ma} * {{WORD_BITS{1'b0}}, mb};
        s   = p >> FRAC_BITS;
        neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        if (s > {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}})
            return neg ? WORD_MIN : WORD_MAX;
        return apply_sign(neg, s[WORD_BITS-1:0]);
    endfunction

    function automatic word_t dir_weight(int dir);
        case (dir)
            0:          return WEIGHT_REST;
            1, 2, 3, 4: return WEIGHT_AXIS;
            default:    return WEIGHT_DIAG;
        endcase
    endfunction

endpackage

// ----- sv/lattice_node_collision_top.sv -----
// Top level of the lattice node collision block: config registers, moments, divide, lanes.
//
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+-------------------------------
//  item     | start, busy, item                         | start && !busy at a rising edge
//  result   | result_valid, result                      | one cycle strobe, no backpressure
//  config   | psel, penable, pwrite, paddr, pwdata,     | write at psel & penable & pwrite
//           | prdata, pready                            | & pready, pready always high
//
//  One item is accepted every cycle; busy stays low.
//  A result strobes after the item passes the moment, divide, velocity, lane and merge registers;
//  most of that depth is the bit-per-stage divider that forms velocity from momentum.
//  Reset clears the valid pipeline and loads register defaults; no clearing pass.
//  The receiver cannot stall, so nothing ever waits inside the pipeline.
module lattice_node_collision_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  lnc_pkg::in_item_t                  item,
    output logic                               result_valid,
    output lnc_pkg::out_item_t                 result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lnc_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [lnc_pkg::DATA_BITS-1:0]      pwdata,
    output logic [lnc_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready
);

    localparam int ND          = lnc_pkg::NUM_DIRS;
    localparam int WB          = lnc_pkg::WORD_BITS;
    localparam int PIPE_DEPTH  = 2 + lnc_pkg::DIV_LAT + 4 + lnc_pkg::LANE_LAT;
    localparam int RESULT_LAT  = PIPE_DEPTH + 1;

    // configuration
    lnc_pkg::word_t                      force_x_reg;
    lnc_pkg::word_t                      force_y_reg;
    logic [lnc_pkg::RELAX_BITS-1:0]      relax_reg;
    logic [lnc_pkg::SOURCE_BITS-1:0]     source_reg;
    lnc_pkg::cfg_reg_t                   cfg_sel;
    logic                                cfg_write;

    assign cfg_sel   = lnc_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_x_reg <= '0;
            force_y_reg <= '0;
            relax_reg   <= lnc_pkg::RELAX_RESET;
            source_reg  <= lnc_pkg::SOURCE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                lnc_pkg::CFG_FORCE_X:       force_x_reg <= lnc_pkg::word_t'(pwdata);
                lnc_pkg::CFG_FORCE_Y:       force_y_reg <= lnc_pkg::word_t'(pwdata);
                lnc_pkg::CFG_RELAX_RATE:    relax_reg   <= pwdata[lnc_pkg::RELAX_BITS-1:0];
                lnc_pkg::CFG_SOURCE_FACTOR: source_reg  <= pwdata[lnc_pkg::SOURCE_BITS-1:0];
                default:                    force_x_reg <= force_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            lnc_pkg::CFG_FORCE_X:       prdata = lnc_pkg::DATA_BITS'(force_x_reg);
            lnc_pkg::CFG_FORCE_Y:       prdata = lnc_pkg::DATA_BITS'(force_y_reg);
            lnc_pkg::CFG_RELAX_RATE:    prdata = lnc_pkg::DATA_BITS'(relax_reg);
            lnc_pkg::CFG_SOURCE_FACTOR: prdata = lnc_pkg::DATA_BITS'(source_reg);
            default:                    prdata = '0;
        endcase
    end

    // input transfer
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    logic [PIPE_DEPTH-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], accept};
    end

    // moments, in two halves
    lnc_pkg::word_t pop_in [ND];
    lnc_pkg::word_t pop_t1_reg [ND];
    lnc_pkg::word_t pop_t2_reg [ND];
    lnc_pkg::word_t rho_t1_reg, mx_t1_reg, my_t1_reg, fx_t1_reg, fy_t1_reg;
    lnc_pkg::word_t rho_t2_reg, mx_t2_reg, my_t2_reg, fx_t2_reg, fy_t2_reg;
    lnc_pkg::word_t rho_t1_next, mx_t1_next, my_t1_next;
    lnc_pkg::word_t rho_t2_next, mx_t2_next, my_t2_next;

    always_comb
    begin
        pop_in[0] = item.pop_rest;
        pop_in[1] = item.pop_east;
        pop_in[2] = item.pop_north;
        pop_in[3] = item.pop_west;
        pop_in[4] = item.pop_south;
        pop_in[5] = item.pop_northeast;
        pop_in[6] = item.pop_northwest;
        pop_in[7] = item.pop_southwest;
        pop_in[8] = item.pop_southeast;

        rho_t1_next = lnc_pkg::sat_add(pop_in[0], pop_in[1]);
        rho_t1_next = lnc_pkg::sat_add(rho_t1_next, pop_in[2]);
        rho_t1_next = lnc_pkg::sat_add(rho_t1_next, pop_in[3]);
        rho_t1_next = lnc_pkg::sat_add(rho_t1_next, pop_in[4]);
        mx_t1_next  = lnc_pkg::sat_add(lnc_pkg::sat_sub(pop_in[1], pop_in[3]), pop_in[5]);
        my_t1_next  = lnc_pkg::sat_add(lnc_pkg::sat_sub(pop_in[2], pop_in[4]), pop_in[5]);

        rho_t2_next = lnc_pkg::sat_add(rho_t1_reg, pop_t1_reg[5]);
        rho_t2_next = lnc_pkg::sat_add(rho_t2_next, pop_t1_reg[6]);
        rho_t2_next = lnc_pkg::sat_add(rho_t2_next, pop_t1_reg[7]);
        rho_t2_next = lnc_pkg::sat_add(rho_t2_next, pop_t1_reg[8]);
        mx_t2_next  = lnc_pkg::sat_sub(mx_t1_reg, pop_t1_reg[6]);
        mx_t2_next  = lnc_pkg::sat_sub(mx_t2_next, pop_t1_reg[7]);
        mx_t2_next  = lnc_pkg::sat_add(mx_t2_next, pop_t1_reg[8]);
        my_t2_next  = lnc_pkg::sat_add(my_t1_reg, pop_t1_reg[6]);
        my_t2_next  = lnc_pkg::sat_sub(my_t2_next, pop_t1_reg[7]);
        my_t2_next  = lnc_pkg::sat_sub(my_t2_next, pop_t1_reg[8]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ND; k++)
        begin
            pop_t1_reg[k] <= pop_in[k];
            pop_t2_reg[k] <= pop_t1_reg[k];
        end
        rho_t1_reg <= rho_t1_next;
        mx_t1_reg  <= mx_t1_next;
        my_t1_reg  <= my_t1_next;
        fx_t1_reg  <= force_x_reg;
        fy_t1_reg  <= item.force_row ? force_y_reg : '0;
        rho_t2_reg <= rho_t2_next;
        mx_t2_reg  <= mx_t2_next;
        my_t2_reg  <= my_t2_next;
        fx_t2_reg  <= fx_t1_reg;
        fy_t2_reg  <= fy_t1_reg;
    end

    // divide, with side data held alongside
    logic               bad_t2;
    lnc_pkg::word_t     den_t2;
    lnc_pkg::node_side_t side_t2;
    lnc_pkg::node_side_t side_dly_reg [lnc_pkg::DIV_LAT];
    lnc_pkg::word_t     quo_x, quo_y;

    always_comb
    begin
        bad_t2 = rho_t2_reg[WB-1] || (rho_t2_reg == '0);
        den_t2 = bad_t2 ? lnc_pkg::word_t'(1) : rho_t2_reg;
        for (int k = 0; k < ND; k++)
            side_t2.pop[k] = pop_t2_reg[k];
        side_t2.rho     = rho_t2_reg;
        side_t2.force_x = fx_t2_reg;
        side_t2.force_y = fy_t2_reg;
        side_t2.bad     = bad_t2;
    end

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= side_t2;
        for (int i = 1; i < lnc_pkg::DIV_LAT; i++)
            side_dly_reg[i] <= side_dly_reg[i-1];
    end

    lnc_div u_div_x (
        .clk (clk),
        .num (mx_t2_reg),
        .den (den_t2),
        .quo (quo_x)
    );

    lnc_div u_div_y (
        .clk (clk),
        .num (my_t2_reg),
        .den (den_t2),
        .quo (quo_y)
    );

    // velocity and its products
    lnc_pkg::node_side_t side_div, side_u1_reg, side_u2_reg, side_u3_reg, side_u4_reg;
    lnc_pkg::word_t ux_u1_reg, uy_u1_reg, ux_u2_reg, uy_u2_reg, ux_u3_reg, uy_u3_reg;
    lnc_pkg::word_t sqx_u2_reg, sqy_u2_reg, fux_u2_reg, fuy_u2_reg;
    lnc_pkg::word_t usq_u3_reg, uf_u3_reg;
    lnc_pkg::word_t ux_u1_next, uy_u1_next;
    lnc_pkg::lane_ctx_t ctx_u4_reg;
    lnc_pkg::lane_ctx_t ctx_u4_next;

    assign side_div = side_dly_reg[lnc_pkg::DIV_LAT-1];

    always_comb
    begin
        ux_u1_next = side_div.bad ? '0 :
            lnc_pkg::sat_add(quo_x, lnc_pkg::half_tz(side_div.force_x));
        uy_u1_next = side_div.bad ? '0 :
            lnc_pkg::sat_add(quo_y, lnc_pkg::half_tz(side_div.force_y));

        ctx_u4_next.vel_x      = ux_u3_reg;
        ctx_u4_next.vel_y      = uy_u3_reg;
        ctx_u4_next.force_x    = side_u3_reg.force_x;
        ctx_u4_next.force_y    = side_u3_reg.force_y;
        ctx_u4_next.rho        = side_u3_reg.rho;
        ctx_u4_next.usq_scaled = lnc_pkg::sat_add(usq_u3_reg, lnc_pkg::half_tz(usq_u3_reg));
        ctx_u4_next.uf_scaled  = lnc_pkg::times3(uf_u3_reg);
    end

    always_ff @(posedge clk)
    begin
        side_u1_reg <= side_div;
        ux_u1_reg   <= ux_u1_next;
        uy_u1_reg   <= uy_u1_next;

        side_u2_reg <= side_u1_reg;
        ux_u2_reg   <= ux_u1_reg;
        uy_u2_reg   <= uy_u1_reg;
        sqx_u2_reg  <= lnc_pkg::sat_mul(ux_u1_reg, ux_u1_reg);
        sqy_u2_reg  <= lnc_pkg::sat_mul(uy_u1_reg, uy_u1_reg);
        fux_u2_reg  <= lnc_pkg::sat_mul(ux_u1_reg, side_u1_reg.force_x);
        fuy_u2_reg  <= lnc_pkg::sat_mul(uy_u1_reg, side_u1_reg.force_y);

        side_u3_reg <= side_u2_reg;
        ux_u3_reg   <= ux_u2_reg;
        uy_u3_reg   <= uy_u2_reg;
        usq_u3_reg  <= lnc_pkg::sat_add(sqx_u2_reg, sqy_u2_reg);
        uf_u3_reg   <= lnc_pkg::sat_add(fux_u2_reg, fuy_u2_reg);

        side_u4_reg <= side_u3_reg;
        ctx_u4_reg  <= ctx_u4_next;
    end

    // lanes, velocity held to match their depth
    lnc_pkg::word_t     lane_out [ND];
    lnc_pkg::vel_info_t vel_dly_reg [lnc_pkg::LANE_LAT];

    always_ff @(posedge clk)
    begin
        vel_dly_reg[0].vel_x <= ctx_u4_reg.vel_x;
        vel_dly_reg[0].vel_y <= ctx_u4_reg.vel_y;
        vel_dly_reg[0].bad   <= side_u4_reg.bad;
        for (int i = 1; i < lnc_pkg::LANE_LAT; i++)
            vel_dly_reg[i] <= vel_dly_reg[i-1];
    end

    for (genvar k = 0; k < ND; k++)
    begin : g_lane
        lnc_lane #(
            .DIR (k)
        ) u_lane (
            .clk           (clk),
            .ctx           (ctx_u4_reg),
            .pop           (side_u4_reg.pop[k]),
            .relax_rate    (relax_reg),
            .source_factor (source_reg),
            .result        (lane_out[k])
        );
    end

    lnc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (vld_reg[PIPE_DEPTH-1]),
        .pops         (lane_out),
        .info         (vel_dly_reg[lnc_pkg::LANE_LAT-1]),
        .result_valid (result_valid),
        .result       (result)
    );

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##RESULT_LAT result_valid)
        else $error("accepted item produced no result");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, RESULT_LAT))
        else $error("result without an accepted item");

endmodule

// ----- sv/lnc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturated signed result.
module lnc_div (
    input  logic          clk,
    input  lnc_pkg::word_t num,
    input  lnc_pkg::word_t den,
    output lnc_pkg::word_t quo
);

    localparam int WB = lnc_pkg::WORD_BITS;
    localparam int QB = lnc_pkg::QUO_BITS;

    logic [WB-1:0] rem_reg [QB];
    logic [QB-1:0] dvd_reg [QB];
    logic [WB-1:0] den_reg [QB];
    logic [QB-1:0] quo_reg [QB+1];
    logic          neg_reg [QB+1];
    lnc_pkg::word_t quo_out_reg;
    lnc_pkg::word_t quo_next;
    logic [WB-1:0]  mag_next;

    always_comb
    begin
        mag_next = num[WB-1] ? (~num + 1'b1) : num;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        dvd_reg[0] <= {mag_next, {lnc_pkg::FRAC_BITS{1'b0}}};
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        neg_reg[0] <= num[WB-1];
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_step
        logic [WB-1:0] trial;
        logic [WB-1:0] diff;
        logic          fit;

        always_comb
        begin
            trial = {rem_reg[i][WB-2:0], dvd_reg[i][QB-1]};
            fit   = trial >= den_reg[i];
            diff  = trial - den_reg[i];
        end

        always_ff @(posedge clk)
        begin
            quo_reg[i+1] <= {quo_reg[i][QB-2:0], fit};
            neg_reg[i+1] <= neg_reg[i];
        end

        if (i < QB - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[i+1] <= fit ? diff : trial;
                dvd_reg[i+1] <= {dvd_reg[i][QB-2:0], 1'b0};
                den_reg[i+1] <= den_reg[i];
            end
        end
    end

    always_comb
    begin
        if (quo_reg[QB] > {{(lnc_pkg::FRAC_BITS+1){1'b0}}, {(WB-1){1'b1}}})
            quo_next = neg_reg[QB] ? lnc_pkg::WORD_MIN : lnc_pkg::WORD_MAX;
        else
            quo_next = lnc_pkg::apply_sign(neg_reg[QB], quo_reg[QB][WB-1:0]);
    end

    always_ff @(posedge clk)
    begin
        quo_out_reg <= quo_next;
    end

    assign quo = quo_out_reg;

endmodule

// ----- sv/lnc_lane.sv -----
// One direction lane: equilibrium, forcing term and relaxation over seven stages.
module lnc_lane #(
    parameter int DIR = 0
) (
    input  logic                               clk,
    input  lnc_pkg::lane_ctx_t                 ctx,
    input  lnc_pkg::word_t                     pop,
    input  logic [lnc_pkg::RELAX_BITS-1:0]     relax_rate,
    input  logic [lnc_pkg::SOURCE_BITS-1:0]    source_factor,
    output lnc_pkg::word_t                     result
);

    localparam int             EX     = lnc_pkg::DIR_X[DIR];
    localparam int             EY     = lnc_pkg::DIR_Y[DIR];
    localparam lnc_pkg::word_t WEIGHT = lnc_pkg::dir_weight(DIR);

    lnc_pkg::word_t eu_reg, ef_reg, wr1_reg, f1_reg, usq1_reg, uf1_reg;
    lnc_pkg::word_t eu2_reg, efeu_reg, eu3_reg, ef3_reg, wr2_reg, f2_reg, usq2_reg, uf2_reg;
    lnc_pkg::word_t poly_reg, srca_reg, wr3_reg, f3_reg;
    lnc_pkg::word_t feq_reg, ws_reg, f4_reg;
    lnc_pkg::word_t diff_reg, src5_reg, f5_reg;
    lnc_pkg::word_t m_reg, src6_reg, f6_reg;
    lnc_pkg::word_t out_reg;

    lnc_pkg::word_t poly_next, srca_next, out_next;

    always_comb
    begin
        poly_next = lnc_pkg::sat_add(lnc_pkg::ONE_Q, eu3_reg);
        poly_next = lnc_pkg::sat_add(poly_next,
                        lnc_pkg::sat_add(lnc_pkg::times4(eu2_reg), lnc_pkg::half_tz(eu2_reg)));
        poly_next = lnc_pkg::sat_sub(poly_next, usq2_reg);
        srca_next = lnc_pkg::sat_sub(lnc_pkg::sat_add(ef3_reg, lnc_pkg::times9(efeu_reg)),
                                     uf2_reg);
        out_next  = lnc_pkg::sat_add(lnc_pkg::sat_sub(f6_reg, m_reg), src6_reg);
    end

    always_ff @(posedge clk)
    begin
        eu_reg   <= lnc_pkg::sat_add(lnc_pkg::pick(EX, ctx.vel_x), lnc_pkg::pick(EY, ctx.vel_y));
        ef_reg   <= lnc_pkg::sat_add(lnc_pkg::pick(EX, ctx.force_x),
                                     lnc_pkg::pick(EY, ctx.force_y));
        wr1_reg  <= lnc_pkg::sat_mul(WEIGHT, ctx.rho);
        f1_reg   <= pop;
        usq1_reg <= ctx.usq_scaled;
        uf1_reg  <= ctx.uf_scaled;

        eu2_reg  <= lnc_pkg::sat_mul(eu_reg, eu_reg);
        efeu_reg <= lnc_pkg::sat_mul(ef_reg, eu_reg);
        eu3_reg  <= lnc_pkg::times3(eu_reg);
        ef3_reg  <= lnc_pkg::times3(ef_reg);
        wr2_reg  <= wr1_reg;
        f2_reg   <= f1_reg;
        usq2_reg <= usq1_reg;
        uf2_reg  <= uf1_reg;

        poly_reg <= poly_next;
        srca_reg <= srca_next;
        wr3_reg  <= wr2_reg;
        f3_reg   <= f2_reg;

        feq_reg  <= lnc_pkg::sat_mul(wr3_reg, poly_reg);
        ws_reg   <= lnc_pkg::sat_mul(WEIGHT, srca_reg);
        f4_reg   <= f3_reg;

        diff_reg <= lnc_pkg::sat_sub(f4_reg, feq_reg);
        src5_reg <= lnc_pkg::sat_mul(lnc_pkg::word_t'(source_factor), ws_reg);
        f5_reg   <= f4_reg;

        m_reg    <= lnc_pkg::sat_mul(diff_reg, lnc_pkg::word_t'(relax_rate));
        src6_reg <= src5_reg;
        f6_reg   <= f5_reg;

        out_reg  <= out_next;
    end

    assign result = out_reg;

endmodule

// ----- sv/lnc_merge.sv -----
// Output stage: gather the nine lane results and the velocity into one result transfer.
module lnc_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  lnc_pkg::word_t      pops [lnc_pkg::NUM_DIRS],
    input  lnc_pkg::vel_info_t  info,
    output logic                result_valid,
    output lnc_pkg::out_item_t  result
);

    logic               valid_reg;
    lnc_pkg::out_item_t result_reg;
    lnc_pkg::out_item_t result_next;

    always_comb
    begin
        result_next.out_rest      = pops[0];
        result_next.out_east      = pops[1];
        result_next.out_north     = pops[2];
        result_next.out_west      = pops[3];
        result_next.out_south     = pops[4];
        result_next.out_northeast = pops[5];
        result_next.out_northwest = pops[6];
        result_next.out_southwest = pops[7];
        result_next.out_southeast = pops[8];
        result_next.velocity_x    = info.vel_x;
        result_next.velocity_y    = info.vel_y;
        result_next.bad_density   = info.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_bad_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_density |->
            result.velocity_x == '0 && result.velocity_y == '0)
        else $error("velocity not zeroed on bad density");

endmodule

// ----- tb/sv/lattice_node_collision_top_test.sv -----
// Self-checking bench for the lattice node collision block: reset readback, directed, random, register sweeps.
module lattice_node_collision_top_test;
    import lnc_pkg::*;

    localparam int LATENCY = WORD_BITS + FRAC_BITS + 15;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_item_t item;
    logic result_valid;
    out_item_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic pready;

    lattice_node_collision_top i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef logic signed [65:0] wide_t;

    localparam wide_t W_MAX = 66'sd2147483647;
    localparam wide_t W_MIN = -66'sd2147483648;
    localparam wide_t ONE_V = 66'sd268435456;

    word_t force_x_reg;
    word_t force_y_reg;
    wide_t relax_reg;
    wide_t source_reg;

    out_item_t collision_q[$];
    int errors;
    int transfers;
    int results_seen;
    int send_idle_pct;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic wide_t clip(wide_t a);
        if (a > W_MAX)
            return W_MAX;
        if (a < W_MIN)
            return W_MIN;
        return a;
    endfunction

    function automatic wide_t qmul(wide_t a, wide_t b);
        logic [127:0] p;
        logic [127:0] s;
        logic [63:0] ma;
        logic [63:0] mb;
        logic neg;
        ma = 64'(a < 0 ? -a : a);
        mb = 64'(b < 0 ? -b : b);
        neg = (a < 0) != (b < 0);
        p = {64'd0, ma} * {64'd0, mb};
        s = p >> FRAC_BITS;
        if (s > 128'd2147483647)
            return neg ? W_MIN : W_MAX;
        return neg ? -wide_t'(s) : wide_t'(s);
    endfunction

    function automatic wide_t qdiv(wide_t a, wide_t b);
        logic [127:0] m;
        logic [127:0] q;
        logic neg;
        neg = a < 0;
        m = 128'(a < 0 ? -a : a);
        q = (m << FRAC_BITS) / 128'(b);
        if (q > 128'd2147483647)
            return neg ? W_MIN : W_MAX;
        return neg ? -wide_t'(q) : wide_t'(q);
    endfunction

    function automatic wide_t halve(wide_t a);
        return a < 0 ? -((-a) >>> 1) : a >>> 1;
    endfunction

    function automatic wide_t signed_dir(int e, wide_t v);
        if (e > 0)
            return v;
        if (e < 0)
            return clip(-v);
        return 0;
    endfunction

    function automatic out_item_t predict_collision(in_item_t n);
        wide_t f[9];
        wide_t w;
        wide_t rho;
        wide_t mx;
        wide_t my;
        wide_t ux;
        wide_t uy;
        wide_t fx;
        wide_t fy;
        wide_t usq;
        wide_t uf;
        wide_t eu;
        wide_t ef;
        wide_t eu2;
        wide_t poly;
        wide_t feq;
        wide_t src;
        wide_t post[9];
        out_item_t r;
        f[0] = n.pop_rest;
        f[1] = n.pop_east;
        f[2] = n.pop_north;
        f[3] = n.pop_west;
        f[4] = n.pop_south;
        f[5] = n.pop_northeast;
        f[6] = n.pop_northwest;
        f[7] = n.pop_southwest;
        f[8] = n.pop_southeast;
        rho = 0;
        for (int k = 0; k < 9; k++)
            rho = clip(rho + f[k]);
        fx = force_x_reg;
        fy = n.force_row ? wide_t'(force_y_reg) : 0;
        mx = clip(clip(clip(clip(clip(f[1] - f[3]) + f[5]) - f[6]) - f[7]) + f[8]);
        my = clip(clip(clip(clip(clip(f[2] - f[4]) + f[5]) + f[6]) - f[7]) - f[8]);
        ux = 0;
        uy = 0;
        if (rho > 0)
        begin
            ux = clip(qdiv(mx, rho) + halve(fx));
            uy = clip(qdiv(my, rho) + halve(fy));
        end
        usq = clip(qmul(ux, ux) + qmul(uy, uy));
        uf = clip(qmul(ux, fx) + qmul(uy, fy));
        for (int k = 0; k < 9; k++)
        begin
            w = k == 0 ? 66'sd119304647 : (k < 5 ? 66'sd29826162 : 66'sd7456540);
            eu = clip(signed_dir(DIR_X[k], ux) + signed_dir(DIR_Y[k], uy));
            ef = clip(signed_dir(DIR_X[k], fx) + signed_dir(DIR_Y[k], fy));
            eu2 = qmul(eu, eu);
            poly = clip(ONE_V + clip(3 * eu));
            poly = clip(poly + clip(clip(4 * eu2) + halve(eu2)));
            poly = clip(poly - clip(usq + halve(usq)));
            feq = qmul(qmul(w, rho), poly);
            src = clip(clip(clip(3 * ef) + clip(9 * qmul(ef, eu))) - clip(3 * uf));
            src = qmul(source_reg, qmul(w, src));
            post[k] = clip(clip(f[k] - qmul(clip(f[k] - feq), relax_reg)) + src);
        end
        r.out_rest = word_t'(post[0]);
        r.out_east = word_t'(post[1]);
        r.out_north = word_t'(post[2]);
        r.out_west = word_t'(post[3]);
        r.out_south = word_t'(post[4]);
        r.out_northeast = word_t'(post[5]);
        r.out_northwest = word_t'(post[6]);
        r.out_southwest = word_t'(post[7]);
        r.out_southeast = word_t'(post[8]);
        r.velocity_x = word_t'(ux);
        r.velocity_y = word_t'(uy);
        r.bad_density = rho <= 0;
        return r;
    endfunction

    task automatic send_node(in_item_t n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        collision_q.push_back(predict_collision(n));
        transfers++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (collision_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = collision_q.pop_front();
                if (e != result)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, result);
                    $display("%0t: vel expected %h %h bad %b actual %h %h bad %b", $time,
                             e.velocity_x, e.velocity_y, e.bad_density,
                             result.velocity_x, result.velocity_y, result.bad_density);
                    errors++;
                end
            end
        end
    end

    task automatic drain;
        start <= 1'b0;
        while (collision_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_BITS'(4 * int'(idx));
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            CFG_FORCE_X: force_x_reg = word_t'(v);
            CFG_FORCE_Y: force_y_reg = word_t'(v);
            CFG_RELAX_RATE: relax_reg = wide_t'(v[RELAX_BITS-1:0]);
            default: source_reg = wide_t'(v[SOURCE_BITS-1:0]);
        endcase
    endtask

    task automatic set_regs(logic [31:0] fx, logic [31:0] fy, logic [31:0] rr, logic [31:0] sf);
        drain();
        write_reg(CFG_FORCE_X, fx);
        write_reg(CFG_FORCE_Y, fy);
        write_reg(CFG_RELAX_RATE, rr);
        write_reg(CFG_SOURCE_FACTOR, sf);
    endtask

    function automatic word_t pop_value(int spread);
        case ($urandom_range(9))
            0: return word_t'($urandom());
            1: return WORD_MAX;
            2: return WORD_MIN;
            default: return word_t'($urandom_range(spread)) - word_t'(spread / 8);
        endcase
    endfunction

    function automatic in_item_t random_node(bit physical);
        in_item_t n;
        logic [32*9-1:0] bits;
        if (!physical)
        begin
            for (int k = 0; k < 9; k++)
                bits[32*k +: 32] = $urandom();
            n = in_item_t'({bits, 1'($urandom())});
            return n;
        end
        n.pop_rest = 32'sd119304647 + word_t'($urandom_range(4000000)) - 32'sd2000000;
        n.pop_east = 32'sd29826162 + word_t'($urandom_range(4000000)) - 32'sd2000000;
        n.pop_north = 32'sd29826162 + word_t'($urandom_range(4000000)) - 32'sd2000000;
        n.pop_west = 32'sd29826162 + word_t'($urandom_range(4000000)) - 32'sd2000000;
        n.pop_south = 32'sd29826162 + word_t'($urandom_range(4000000)) - 32'sd2000000;
        n.pop_northeast = 32'sd7456540 + word_t'($urandom_range(1000000)) - 32'sd500000;
        n.pop_northwest = 32'sd7456540 + word_t'($urandom_range(1000000)) - 32'sd500000;
        n.pop_southwest = 32'sd7456540 + word_t'($urandom_range(1000000)) - 32'sd500000;
        n.pop_southeast = 32'sd7456540 + word_t'($urandom_range(1000000)) - 32'sd500000;
        n.force_row = 1'($urandom());
        if ($urandom_range(9) == 0)
            n.pop_east = pop_value(32'h7fffffff);
        return n;
    endfunction

    task automatic test_directed;
        in_item_t n;
        n = '0;
        send_node(n);
        n = '1;
        send_node(n);
        n = {{9{WORD_MAX}}, 1'b1};
        send_node(n);
        n = {{9{WORD_MIN}}, 1'b0};
        send_node(n);
        n = random_node(1);
        n.pop_rest = -32'sd300000000;
        send_node(n);
        for (int k = 0; k < 9; k++)
        begin
            logic [32*9-1:0] b;
            b = '0;
            b[32*(8-k) +: 32] = ONE_Q;
            send_node(in_item_t'({b, 1'b1}));
            b[32*(8-k) +: 32] = WORD_MIN;
            send_node(in_item_t'({b, 1'b0}));
        end
        n = random_node(1);
        n.pop_northeast = WORD_MAX;
        send_node(n);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_node(random_node($urandom_range(3) != 0));
    endtask

    task automatic test_register_sweep;
        set_regs(32'h0010_0000, 32'hfff0_0000, 32'h1000_0000, 32'h0800_0000);
        test_random(350);
        set_regs(32'h7fffffff, 32'h80000000, 32'h2000_0000, 32'h1000_0000);
        test_random(150);
        set_regs(32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
        test_random(150);
        set_regs(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        test_random(100);
        set_regs($urandom(), $urandom(), $urandom_range(32'h2000_0000),
                 $urandom_range(32'h1000_0000));
        test_random(250);
    endtask

    task automatic test_reset_values;
        n_check_readback();
    endtask

    task automatic n_check_readback;
        logic [31:0] exp_v;
        for (int i = 0; i < 4; i++)
        begin
            case (cfg_reg_t'(i))
                CFG_FORCE_X: exp_v = 32'(force_x_reg);
                CFG_FORCE_Y: exp_v = 32'(force_y_reg);
                CFG_RELAX_RATE: exp_v = 32'(relax_reg);
                default: exp_v = 32'(source_reg);
            endcase
            psel <= 1'b1;
            pwrite <= 1'b0;
            penable <= 1'b0;
            paddr <= ADDR_BITS'(4 * i);
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata != exp_v)
            begin
                $display("%0t: register %0d expected %h actual %h", $time, i, exp_v, prdata);
                errors++;
            end
            @(negedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        transfers = 0;
        results_seen = 0;
        force_x_reg = '0;
        force_y_reg = '0;
        relax_reg = ONE_V;
        source_reg = ONE_V / 2;
        send_idle_pct = 36;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_values();
        test_directed();
        test_random(300);
        send_idle_pct = 60;
        test_register_sweep();
        send_idle_pct = 0;
        test_random(400);
        drain();
        $display("Covered %0d node transfers and %0d results over six register settings.",
                 transfers, results_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
